// File: src/swm_pkg.sv
// Shared constants for the sliding window maximum unit.
// No dependencies; used by the top level.
package swm_pkg;

  // Width and reset value of the window size register
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

endpackage : swm_pkg

// File: src/swm_cell.sv
// One cell of the running-maximum row: holds the largest sample seen over
// a growing span of ages. No package dependency.
module swm_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           advance,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] left,
  input  logic                           sel,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic        [SAMPLE_WIDTH-1:0] tap
);

  logic signed [SAMPLE_WIDTH-1:0] value_r;
  logic signed [SAMPLE_WIDTH-1:0] value_nxt;

  // Take the larger of the neighbor's running maximum and the new sample
  assign value_nxt = (left > sample) ? left : sample;

  always_ff @(posedge clk) begin
    if (advance) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

  // Drive the shared output bus only when this cell is selected
  assign tap = sel ? value_r : '0;

endmodule : swm_cell

// File: src/sliding_window_maximum_unit.sv
// Sliding window maximum over a stream of signed samples. One transaction
// is accepted per clock unless in_stall is high; the result, when the
// window is full, appears on the output in the next cycle from the output
// stage, and the next sample can be taken in that same cycle. Each of the
// WINDOW_MAX cells compares its neighbor's running maximum against the new
// sample. in_stall rises only while a result is waiting and out_stall is
// high. The window size is written via cfg_wr_en/cfg_window_size; the user
// must write it only while the block is idle; the block does not enforce
// this. Zero is taken as 1, values above WINDOW_MAX as WINDOW_MAX. A
// transaction with in_restart set starts a new sequence. Depends on swm_pkg, swm_cell.
module sliding_window_maximum_unit #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]      cfg_window_size,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_max
);

  localparam int WIN_W = $clog2(WINDOW_MAX + 1);

  // Effective window size from a raw register value
  function automatic logic [WIN_W-1:0] clamp_win(input logic [swm_pkg::CFG_W-1:0] v);
    logic [31:0] v_ext;
    v_ext = 32'(v);
    priority if (v_ext == 32'd0) begin
      clamp_win = WIN_W'(1);
    end else if (v_ext > 32'(WINDOW_MAX)) begin
      clamp_win = WIN_W'(WINDOW_MAX);
    end else begin
      clamp_win = v_ext[WIN_W-1:0];
    end
  endfunction

  logic [WIN_W-1:0]      win_r;
  logic [WIN_W-1:0]      alive_r;
  logic [WIN_W-1:0]      alive_nxt;
  logic [WIN_W-1:0]      filled_r;
  logic [WIN_W-1:0]      filled_nxt;
  logic [WINDOW_MAX-1:0] sel_oh_r;
  logic [WINDOW_MAX-1:0] sel_oh_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  logic                  accept;
  logic [WIN_W-1:0]      alive_base;
  logic [WIN_W-1:0]      filled_base;
  logic [WIN_W:0]        alive_inc;
  logic                  emit;

  logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
  logic        [SAMPLE_WIDTH-1:0] cell_tap [WINDOW_MAX];
  logic        [SAMPLE_WIDTH-1:0] tap_or;

  // Accept a transaction when the output stage is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Restart drops all history before this sample
  assign alive_base  = in_restart ? '0 : alive_r;
  assign filled_base = in_restart ? '0 : filled_r;

  // Count live ages: grow by one, retire everything at or past the window
  assign alive_inc = {1'b0, alive_base} + (WIN_W+1)'(1);
  assign alive_nxt = (alive_inc > {1'b0, win_r}) ? win_r : alive_inc[WIN_W-1:0];

  // Count samples toward a full window, holding once it is reached
  assign filled_nxt = (filled_base < win_r) ? filled_base + WIN_W'(1) : filled_base;
  assign emit       = (filled_nxt >= win_r);

  // Select the cell whose span covers exactly the live ages
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_sel
    assign sel_oh_nxt[k] = (alive_nxt == WIN_W'(k + 1));
  end

  // Load a new result on accept, hold it while stalled, clear it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= clamp_win(swm_pkg::CFG_RESET);
      alive_r     <= '0;
      filled_r    <= '0;
      sel_oh_r    <= WINDOW_MAX'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= clamp_win(cfg_window_size);
      end
      if (accept) begin
        alive_r  <= alive_nxt;
        filled_r <= filled_nxt;
        sel_oh_r <= sel_oh_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Row of running-maximum cells; cell k covers ages 0..k
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk    (clk),
        .advance(accept),
        .sample (in_sample),
        .left   (in_sample),
        .sel    (sel_oh_r[k]),
        .value  (cell_val[k]),
        .tap    (cell_tap[k])
      );
    end else begin : g_body
      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk    (clk),
        .advance(accept),
        .sample (in_sample),
        .left   (cell_val[k-1]),
        .sel    (sel_oh_r[k]),
        .value  (cell_val[k]),
        .tap    (cell_tap[k])
      );
    end
  end

  // Merge the gated cell outputs; exactly one cell drives
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = tap_or;

`ifndef NO_ASSERTIONS
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(sel_oh_r))
    else $error("cell select is not one-hot");

  a_alive_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (alive_r != '0) && (alive_r <= win_r))
    else $error("live span outside window after a transaction");

  a_alive_le_filled: assert property (@(posedge clk) disable iff (!rst_n)
    alive_r <= filled_r)
    else $error("live span exceeds sample count");

  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (filled_r >= win_r))
    else $error("result issued before window filled");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart) |=> (filled_r == WIN_W'(1)) && (alive_r == WIN_W'(1)))
    else $error("restart did not clear history");
`endif

endmodule : sliding_window_maximum_unit

// File: test/sliding_window_maximum_unit_tb.sv
// Self-checking testbench for the sliding window maximum unit: directed and
// random sample streams across many window sizes, checked by a scoreboard.
// Depends on swm_pkg and sliding_window_maximum_unit.
module sliding_window_maximum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAX       = 64;
  localparam int SW         = 32;
  localparam int POS_W      = $clog2(2 * WMAX);
  localparam int HOLD_LEN   = 200;
  localparam int QUIET_MAX  = 3000;
  localparam int N_PHASES   = 14;
  localparam int PHASE_LEN  = 125;
  localparam int N_DIRECTED = 22;
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  // Tracks the candidate deque and the maxima still owed by the block
  class max_tracker_t;
    logic signed [SW-1:0]      cand_value [WMAX];
    logic [POS_W-1:0]          cand_pos [WMAX];
    int                        head;
    int                        len;
    logic [POS_W-1:0]          position;
    int                        filled;
    logic [swm_pkg::CFG_W-1:0] window_reg;
    logic signed [SW-1:0]      expected_max [$];
    int                        errors;

    function new();
      head       = 0;
      len        = 0;
      position   = '0;
      filled     = 0;
      window_reg = swm_pkg::CFG_RESET;
      errors     = 0;
    endfunction

    function void set_window(logic [swm_pkg::CFG_W-1:0] value);
      window_reg = value;
    endfunction

    function int pending();
      return expected_max.size();
    endfunction

    // Advance the deque by one accepted input transaction
    function void note_sample(logic signed [SW-1:0] value, logic restart);
      int               w;
      logic [POS_W-1:0] age;
      w = (window_reg == 0) ? 1 : ((window_reg > WMAX) ? WMAX : int'(window_reg));
      if (restart) begin
        head     = 0;
        len      = 0;
        position = '0;
        filled   = 0;
      end
      // drop strictly smaller candidates from the back
      while (len > 0 && cand_value[(head + len - 1) % WMAX] < value)
        len--;
      // retire front candidates that have aged out of the window
      while (len > 0) begin
        age = position - cand_pos[head];
        if (age < w)
          break;
        head = (head + 1) % WMAX;
        len--;
      end
      if (len < WMAX) begin
        cand_value[(head + len) % WMAX] = value;
        cand_pos[(head + len) % WMAX]   = position;
        len++;
      end
      position++;
      if (filled < w)
        filled++;
      if (filled >= w)
        expected_max = {expected_max, cand_value[head]};
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_max(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (expected_max.size() == 0) begin
        $error("window_max: expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_max[0];
        expected_max.delete(0);
        if (got !== want) begin
          $error("window_max: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      cfg_wr_en       = 1'b0;
  logic [swm_pkg::CFG_W-1:0] cfg_window_size = '0;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic signed [SW-1:0]      in_sample       = '0;
  logic                      in_restart      = 1'b0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic signed [SW-1:0]      out_window_max;

  max_tracker_t         tracker;
  bit                   no_idle      = 1'b0;
  int                   results_seen = 0;
  int                   quiet_cycles = 0;
  int                   hold_left    = 0;
  int                   holds_done   = 0;
  logic signed [SW-1:0] ramp_value   = '0;
  bit                   ramp_down    = 1'b1;

  sliding_window_maximum_unit #(
    .WINDOW_MAX  (WMAX),
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_window_size(cfg_window_size),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max)
  );

  always #5 clk = ~clk;

  // Score both channels and watch for a hung pipeline
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_max(out_window_max);
        results_seen++;
      end
      if (in_valid && !in_stall)
        tracker.note_sample(in_sample, in_restart);
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("sliding_window_maximum_unit regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs to back up the input
  always @(negedge clk) begin
    if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 900)) begin
      hold_left = HOLD_LEN;
      holds_done++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!no_idle && $urandom_range(99) < 34) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Mix of random words, near-equal values, extremes and slow ramps
  function automatic logic signed [SW-1:0] pick_sample();
    int unsigned roll;
    int unsigned step;
    roll = $urandom_range(99);
    if (roll < 30)
      return $urandom;
    if (roll < 50)
      return $signed(SW'($urandom_range(6))) - 3;
    if (roll < 60) begin
      unique case ($urandom_range(3))
        0: return S_MIN;
        1: return S_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    // ramps that rise or fall; falling runs make the deque run deep
    step = $urandom_range(3);
    if ($urandom_range(19) == 0)
      ramp_down = !ramp_down;
    if ($urandom_range(49) == 0)
      ramp_value = $urandom;
    else if (ramp_down)
      ramp_value = ramp_value - step;
    else
      ramp_value = ramp_value + step;
    return ramp_value;
  endfunction

  // Offer one input transaction and hold it until it is taken
  task automatic push_sample(input logic signed [SW-1:0] value, input logic restart);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= value;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Stop sending, wait out every owed result, then write the window size
  task automatic drain_and_write(input logic [swm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_window_size <= value;
    cfg_wr_en       <= 1'b1;
    tracker.set_window(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic signed [SW-1:0] dir_sample [N_DIRECTED] = '{
    S_MIN, S_MAX, 0, -1, -1, -1, S_MAX, S_MAX, 5, 4, 3,
    2, 1, S_MIN, S_MIN, 7, 8, S_MIN, -1, 0, 1, -5
  };
  logic dir_restart [N_DIRECTED] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0
  };
  // Window per phase, with under/over-range values; a set bit in
  // keep_going continues the running sequence across the size change
  logic [swm_pkg::CFG_W-1:0] phase_window [N_PHASES] = '{
    1, 0, 4, 64, 2, 127, 9, 3, 65, 16, 1, 40, 6, 2
  };
  bit keep_going [N_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0, 0, 1};

  initial begin
    int eff;
    int odds;
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed run at the reset window size
    for (int i = 0; i < N_DIRECTED; i++)
      push_sample(dir_sample[i], dir_restart[i]);

    // random phases over a range of window sizes
    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_write(phase_window[p]);
      no_idle = (p == 4 || p == 5);
      eff     = (phase_window[p] == 0) ? 1 :
                ((phase_window[p] > WMAX) ? WMAX : int'(phase_window[p]));
      odds    = (eff > 20) ? 0 : 50;
      for (int k = 0; k < PHASE_LEN; k++)
        push_sample(pick_sample(),
                    (k == 0 && !keep_going[p]) || (odds != 0 && $urandom_range(odds - 1) == 0));
    end
    no_idle = 1'b0;

    // wait for the last results, then let the pipeline settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (tracker.errors == 0)
      $display("sliding_window_maximum_unit regression: pass");
    else
      $display("sliding_window_maximum_unit regression: fail");
    $finish;
  end

endmodule : sliding_window_maximum_unit_tb
